// ===== design/triangle_tangent_bitangent_unit_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef TRIANGLE_TANGENT_BITANGENT_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttb same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttb next-cycle check failed");

`endif

// ===== design/ttb_pkg.sv =====
`default_nettype none
package ttb_pkg;

    localparam int VERTEX_SLOTS = 256;
    localparam int SLOT_W       = 8;
    localparam int ADDR_W       = $clog2(VERTEX_SLOTS);
    localparam int COORD_W      = 16;
    localparam int POS_W        = 3 * COORD_W;
    localparam int TEX_W        = 2 * COORD_W;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int TERM_W       = PROD_W + 1;
    localparam int MAG_W        = TERM_W;
    localparam int NORM_W       = 31;
    localparam int SHIFT_MAX    = MAG_W - NORM_W;
    localparam int SQ_W         = 64;
    localparam int ROOT_W       = 32;
    localparam int UNIT_SHIFT   = 14;
    localparam int UNIT_ONE     = 1 << UNIT_SHIFT;
    localparam int OUT_W        = 16;
    localparam int QUOT_W       = 16;
    localparam int NUM_W        = NORM_W + UNIT_SHIFT + 1;
    localparam int REM_W        = ROOT_W + 1;
    localparam int TERMS        = 7;
    localparam int MUL_STEPS    = 2 * TERMS;
    localparam int STEP_W       = $clog2(MUL_STEPS);
    localparam int Q_DEPTH      = 2;
    localparam int QP_W         = $clog2(Q_DEPTH);
    localparam int QC_W         = $clog2(Q_DEPTH + 1);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TRI  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [SLOT_W-1:0]         vertex_slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic [SLOT_W-1:0]         first_index;
        logic [SLOT_W-1:0]         second_index;
        logic [SLOT_W-1:0]         third_index;
        logic                      final_triangle;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [COORD_W-1:0] tu;
        logic signed [COORD_W-1:0] tv;
    } vertex_t;

    typedef struct packed {
        logic                     start;
        logic signed [TERM_W-1:0] c0;
        logic signed [TERM_W-1:0] c1;
        logic signed [TERM_W-1:0] c2;
    } norm_req_t;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic signed [OUT_W-1:0] o0;
        logic signed [OUT_W-1:0] o1;
        logic signed [OUT_W-1:0] o2;
    } norm_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE, B_RD0, B_RD1, B_RD2, B_RD3, B_DIFF, B_MUL,
        B_NORM_T, B_WAIT_T, B_NORM_B, B_WAIT_B, B_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DSET, N_DIV, N_DONE
    } norm_state_t;

endpackage
`default_nettype wire

// ===== design/triangle_tangent_bitangent_unit.sv =====
// Tangent/bitangent unit. Load beats (action 0) write one vertex, position and
// texture coordinate in signed Q3.12, into a 256-slot store; triangle beats
// (action 1) name three slots and return three result beats, for the first,
// second and third corner in that order, each with the corner's slot and its
// unit tangent and bitangent in signed Q1.14. A zero UV determinant or a
// zero-length vector raises degenerate and zeroes the six components.
// corner_last marks the third beat of a triangle and mesh_done the third beat
// of the triangle flagged final_triangle. A two-beat queue sits behind the
// input port, so beats are still taken while a result waits on the output.
// A load is written to the store in the cycle it leaves the queue. A triangle
// runs the store reads, then per corner a pass on the single 17x17 multiplier
// and two passes through the normalizer, each a 32-step square root and three
// 16-step restoring divides. Reading a slot that was never loaded gives
// undefined fields.
`default_nettype none
module triangle_tangent_bitangent_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic                               action,
    input  wire logic [ttb_pkg::SLOT_W-1:0]         vertex_slot,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_z,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] tex_u,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] tex_v,
    input  wire logic [ttb_pkg::SLOT_W-1:0]         first_index,
    input  wire logic [ttb_pkg::SLOT_W-1:0]         second_index,
    input  wire logic [ttb_pkg::SLOT_W-1:0]         third_index,
    input  wire logic                               final_triangle,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [ttb_pkg::SLOT_W-1:0]              target_slot,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_z,
    output logic                                    degenerate,
    output logic                                    corner_last,
    output logic                                    mesh_done
);

    // queue head from the front end
    ttb_pkg::item_t                head;
    logic                          head_valid;
    logic                          pop;

    // vertex store ports; the back end does all reads and writes so that
    // loads and triangles keep their arrival order
    logic                          ram_we;
    logic [ttb_pkg::ADDR_W-1:0]    ram_waddr;
    logic [ttb_pkg::ADDR_W-1:0]    ram_raddr;
    logic [ttb_pkg::POS_W-1:0]     pos_wdata, pos_rdata;
    logic [ttb_pkg::TEX_W-1:0]     tex_wdata, tex_rdata;

    // normalizer handshake
    ttb_pkg::norm_req_t            norm_req;
    ttb_pkg::norm_rsp_t            norm_rsp;

    ttb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .vertex_slot    (vertex_slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .first_index    (first_index),
        .second_index   (second_index),
        .third_index    (third_index),
        .final_triangle (final_triangle),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop)
    );

    // position store, {x, y, z}
    ttb_ram #(
        .WIDTH (ttb_pkg::POS_W),
        .DEPTH (ttb_pkg::VERTEX_SLOTS)
    ) u_pos_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pos_wdata),
        .raddr (ram_raddr),
        .rdata (pos_rdata)
    );

    // texture coordinate store, {u, v}
    ttb_ram #(
        .WIDTH (ttb_pkg::TEX_W),
        .DEPTH (ttb_pkg::VERTEX_SLOTS)
    ) u_tex_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tex_wdata),
        .raddr (ram_raddr),
        .rdata (tex_rdata)
    );

    ttb_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

    ttb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .pos_wdata    (pos_wdata),
        .tex_wdata    (tex_wdata),
        .ram_raddr    (ram_raddr),
        .pos_rdata    (pos_rdata),
        .tex_rdata    (tex_rdata),
        .norm_req     (norm_req),
        .norm_rsp     (norm_rsp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .target_slot  (target_slot),
        .tangent_x    (tangent_x),
        .tangent_y    (tangent_y),
        .tangent_z    (tangent_z),
        .bitangent_x  (bitangent_x),
        .bitangent_y  (bitangent_y),
        .bitangent_z  (bitangent_z),
        .degenerate   (degenerate),
        .corner_last  (corner_last),
        .mesh_done    (mesh_done)
    );

endmodule
`default_nettype wire

// ===== design/ttb_ram.sv =====
`default_nettype none
module ttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/ttb_front.sv =====
`default_nettype none
module ttb_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic                              action,
    input  wire logic [ttb_pkg::SLOT_W-1:0]        vertex_slot,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_x,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_y,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] pos_z,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] tex_u,
    input  wire logic signed [ttb_pkg::COORD_W-1:0] tex_v,
    input  wire logic [ttb_pkg::SLOT_W-1:0]        first_index,
    input  wire logic [ttb_pkg::SLOT_W-1:0]        second_index,
    input  wire logic [ttb_pkg::SLOT_W-1:0]        third_index,
    input  wire logic                              final_triangle,
    output ttb_pkg::item_t                         head,
    output logic                                   head_valid,
    input  wire logic                              pop
);

    localparam int QP = ttb_pkg::QP_W;
    localparam int QC = ttb_pkg::QC_W;

    ttb_pkg::item_t  qmem_reg [ttb_pkg::Q_DEPTH];
    ttb_pkg::item_t  incoming;
    logic [QP-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QP-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QC-1:0]   count_reg, count_next;
    logic            push, take;

    // classify: keep only the fields that the item kind uses
    always_comb
    begin
        incoming = '0;
        incoming.action = action;
        if (action == ttb_pkg::ACT_LOAD)
        begin
            incoming.vertex_slot = vertex_slot;
            incoming.pos_x       = pos_x;
            incoming.pos_y       = pos_y;
            incoming.pos_z       = pos_z;
            incoming.tex_u       = tex_u;
            incoming.tex_v       = tex_v;
        end
        else
        begin
            incoming.first_index    = first_index;
            incoming.second_index   = second_index;
            incoming.third_index    = third_index;
            incoming.final_triangle = final_triangle;
        end
    end

    assign item_stall = (count_reg == QC'(ttb_pkg::Q_DEPTH));
    assign push       = item_valid && !item_stall;
    assign head_valid = (count_reg != '0);
    assign take       = pop && head_valid;
    assign head       = qmem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP'(ttb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == QP'(ttb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qmem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule
`default_nettype wire

// ===== design/ttb_norm.sv =====
`default_nettype none
module ttb_norm (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  ttb_pkg::norm_req_t      req,
    output ttb_pkg::norm_rsp_t      rsp
);

    localparam int TW = ttb_pkg::TERM_W;
    localparam int MW = ttb_pkg::MAG_W;
    localparam int NW = ttb_pkg::NORM_W;
    localparam int SW = ttb_pkg::SQ_W;
    localparam int RW = ttb_pkg::ROOT_W;
    localparam int XW = ttb_pkg::REM_W;
    localparam int QW = ttb_pkg::QUOT_W;
    localparam int UW = ttb_pkg::NUM_W;
    localparam int OW = ttb_pkg::OUT_W;

    ttb_pkg::norm_state_t state_reg, state_next;

    logic [MW-1:0]        mag_reg [3];
    logic [2:0]           neg_reg;
    logic [NW-1:0]        m_reg [3];
    logic                 zero_reg;
    logic [SW-1:0]        acc_reg;
    logic [SW-1:0]        root_reg;
    logic [SW-1:0]        bit_reg;
    logic [1:0]           k_reg;
    logic [RW-1:0]        rem_reg;
    logic [QW-1:0]        low_reg;
    logic [QW-1:0]        quot_reg;
    logic [$clog2(QW)-1:0] cnt_reg;
    logic signed [OW-1:0] o_reg [3];

    logic [MW-1:0]        orv;
    logic [2:0]           sh;
    logic [SW-1:0]        rb;
    logic [RW-1:0]        len;
    logic [UW-1:0]        num;
    logic [XW-1:0]        trial;
    logic                 ge;
    logic [QW-1:0]        qnew;
    logic [QW-1:0]        qclamp;

    // shift so that every magnitude fits below 2^31
    always_comb
    begin
        orv = mag_reg[0] | mag_reg[1] | mag_reg[2];
        sh  = '0;
        for (int i = 1; i <= ttb_pkg::SHIFT_MAX; i++)
        begin
            if (orv[NW - 1 + i])
            begin
                sh = 3'(i);
            end
        end
    end

    assign rb    = root_reg + bit_reg;
    assign len   = root_reg[RW-1:0];
    assign num   = (UW'(m_reg[k_reg]) << ttb_pkg::UNIT_SHIFT) + UW'(len >> 1);
    assign trial = {rem_reg, low_reg[QW-1]};
    assign ge    = (trial >= XW'(len));
    assign qnew  = {quot_reg[QW-2:0], ge};
    assign qclamp = (qnew > QW'(ttb_pkg::UNIT_ONE)) ? QW'(ttb_pkg::UNIT_ONE) : qnew;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttb_pkg::N_IDLE:  if (req.start) state_next = ttb_pkg::N_SHIFT;
            ttb_pkg::N_SHIFT: state_next = (orv == '0) ? ttb_pkg::N_DONE : ttb_pkg::N_SQ;
            ttb_pkg::N_SQ:    if (k_reg == 2'd2) state_next = ttb_pkg::N_SQRT;
            ttb_pkg::N_SQRT:  if (bit_reg == SW'(1)) state_next = ttb_pkg::N_DSET;
            ttb_pkg::N_DSET:  state_next = ttb_pkg::N_DIV;
            ttb_pkg::N_DIV:
            begin
                if (cnt_reg == ($clog2(QW))'(QW - 1))
                begin
                    state_next = (k_reg == 2'd2) ? ttb_pkg::N_DONE : ttb_pkg::N_DSET;
                end
            end
            ttb_pkg::N_DONE:  state_next = ttb_pkg::N_IDLE;
            default:          state_next = ttb_pkg::N_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done = (state_reg == ttb_pkg::N_DONE);
        rsp.zero = zero_reg;
        rsp.o0   = o_reg[0];
        rsp.o1   = o_reg[1];
        rsp.o2   = o_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::N_IDLE:
            begin
                neg_reg    <= {req.c2[TW-1], req.c1[TW-1], req.c0[TW-1]};
                mag_reg[0] <= req.c0[TW-1] ? MW'(-req.c0) : MW'(req.c0);
                mag_reg[1] <= req.c1[TW-1] ? MW'(-req.c1) : MW'(req.c1);
                mag_reg[2] <= req.c2[TW-1] ? MW'(-req.c2) : MW'(req.c2);
            end
            ttb_pkg::N_SHIFT:
            begin
                zero_reg <= (orv == '0);
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= NW'(mag_reg[i] >> sh);
                end
                acc_reg <= '0;
                k_reg   <= '0;
            end
            ttb_pkg::N_SQ:
            begin
                acc_reg  <= acc_reg + SW'(m_reg[k_reg]) * SW'(m_reg[k_reg]);
                k_reg    <= k_reg + 1'b1;
                root_reg <= '0;
                bit_reg  <= SW'(1) << (SW - 2);
            end
            ttb_pkg::N_SQRT:
            begin
                if (acc_reg >= rb)
                begin
                    acc_reg  <= acc_reg - rb;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                k_reg   <= '0;
            end
            ttb_pkg::N_DSET:
            begin
                // quotient fits in QW bits, so the top part is already below len
                rem_reg  <= RW'(num >> QW);
                low_reg  <= num[QW-1:0];
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            ttb_pkg::N_DIV:
            begin
                rem_reg  <= ge ? RW'(trial - XW'(len)) : trial[RW-1:0];
                low_reg  <= low_reg << 1;
                quot_reg <= qnew;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(QW))'(QW - 1))
                begin
                    o_reg[k_reg] <= neg_reg[k_reg] ? -OW'(qclamp) : OW'(qclamp);
                    k_reg        <= k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/ttb_back.sv =====
`default_nettype none
module ttb_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  ttb_pkg::item_t                          head,
    input  wire logic                               head_valid,
    output logic                                    pop,
    output logic                                    ram_we,
    output logic [ttb_pkg::ADDR_W-1:0]              ram_waddr,
    output logic [ttb_pkg::POS_W-1:0]               pos_wdata,
    output logic [ttb_pkg::TEX_W-1:0]               tex_wdata,
    output logic [ttb_pkg::ADDR_W-1:0]              ram_raddr,
    input  wire logic [ttb_pkg::POS_W-1:0]          pos_rdata,
    input  wire logic [ttb_pkg::TEX_W-1:0]          tex_rdata,
    output ttb_pkg::norm_req_t                      norm_req,
    input  ttb_pkg::norm_rsp_t                      norm_rsp,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic [ttb_pkg::SLOT_W-1:0]              target_slot,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]        tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]        bitangent_z,
    output logic                                    degenerate,
    output logic                                    corner_last,
    output logic                                    mesh_done
);

    localparam int DW = ttb_pkg::DIFF_W;
    localparam int PW = ttb_pkg::PROD_W;
    localparam int TW = ttb_pkg::TERM_W;
    localparam int OW = ttb_pkg::OUT_W;
    localparam int AW = ttb_pkg::ADDR_W;
    localparam int SP = ttb_pkg::STEP_W;

    ttb_pkg::back_state_t state_reg, state_next;

    logic [ttb_pkg::SLOT_W-1:0] idx_reg [3];
    logic                       final_reg;
    ttb_pkg::vertex_t           vtx_reg [3];
    logic [1:0]                 corner_reg;
    logic signed [DW-1:0]       e1_reg [3];
    logic signed [DW-1:0]       e2_reg [3];
    logic signed [DW-1:0]       d1u_reg, d1v_reg, d2u_reg, d2v_reg;
    logic [SP-1:0]              step_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [TW-1:0]       det_reg;
    logic signed [TW-1:0]       t_reg [3];
    logic signed [TW-1:0]       b_reg [3];
    logic signed [OW-1:0]       tcap_reg [3];
    logic signed [OW-1:0]       bcap_reg [3];
    logic                       zt_reg, zb_reg;

    logic                       ov_reg;
    logic [ttb_pkg::SLOT_W-1:0] slot_out_reg;
    logic signed [OW-1:0]       tan_out_reg [3];
    logic signed [OW-1:0]       bit_out_reg [3];
    logic                       degen_out_reg, last_out_reg, done_out_reg;

    ttb_pkg::vertex_t           va, vb, vc, rd_vtx;
    logic [2:0]                 term_sel;
    logic                       phase;
    logic [1:0]                 lane;
    logic signed [DW-1:0]       mul_a, mul_b;
    logic signed [PW-1:0]       mul_p;
    logic signed [TW-1:0]       term;
    logic                       det_neg, det_zero, out_free, mul_last, degen_now;

    assign rd_vtx   = ttb_pkg::vertex_t'({pos_rdata, tex_rdata});
    assign term_sel = step_reg[SP-1:1];
    assign phase    = step_reg[0];
    assign det_neg  = det_reg[TW-1];
    assign det_zero = (det_reg == '0);
    assign out_free = !ov_reg || !result_stall;
    assign mul_last = (step_reg == SP'(ttb_pkg::MUL_STEPS - 1));
    assign degen_now = det_zero || zt_reg || zb_reg;

    // corner rotation: base, then the other two in cyclic order
    always_comb
    begin
        case (corner_reg)
            2'd1:
            begin
                va = vtx_reg[1]; vb = vtx_reg[2]; vc = vtx_reg[0];
            end
            2'd2:
            begin
                va = vtx_reg[2]; vb = vtx_reg[0]; vc = vtx_reg[1];
            end
            default:
            begin
                va = vtx_reg[0]; vb = vtx_reg[1]; vc = vtx_reg[2];
            end
        endcase
    end

    // one shared multiplier: even step x*y, odd step prod - z*w
    always_comb
    begin
        lane  = '0;
        mul_a = d1u_reg;
        mul_b = d2v_reg;
        case (term_sel)
            3'd0:
            begin
                mul_a = phase ? d2u_reg : d1u_reg;
                mul_b = phase ? d1v_reg : d2v_reg;
            end
            3'd1, 3'd2, 3'd3:
            begin
                lane  = 2'(term_sel - 3'd1);
                mul_a = phase ? d1v_reg : d2v_reg;
                mul_b = phase ? e2_reg[lane] : e1_reg[lane];
            end
            3'd4, 3'd5, 3'd6:
            begin
                lane  = 2'(term_sel - 3'd4);
                mul_a = phase ? d2u_reg : d1u_reg;
                mul_b = phase ? e1_reg[lane] : e2_reg[lane];
            end
            default:
            begin
                lane = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);
    assign term  = TW'(prod_reg) - TW'(mul_p);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttb_pkg::B_IDLE:
            begin
                if (head_valid && head.action == ttb_pkg::ACT_TRI)
                begin
                    state_next = ttb_pkg::B_RD0;
                end
            end
            ttb_pkg::B_RD0:  state_next = ttb_pkg::B_RD1;
            ttb_pkg::B_RD1:  state_next = ttb_pkg::B_RD2;
            ttb_pkg::B_RD2:  state_next = ttb_pkg::B_RD3;
            ttb_pkg::B_RD3:  state_next = ttb_pkg::B_DIFF;
            ttb_pkg::B_DIFF: state_next = ttb_pkg::B_MUL;
            ttb_pkg::B_MUL:
            begin
                if (mul_last)
                begin
                    state_next = det_zero ? ttb_pkg::B_OUT : ttb_pkg::B_NORM_T;
                end
            end
            ttb_pkg::B_NORM_T: state_next = ttb_pkg::B_WAIT_T;
            ttb_pkg::B_WAIT_T: if (norm_rsp.done) state_next = ttb_pkg::B_NORM_B;
            ttb_pkg::B_NORM_B: state_next = ttb_pkg::B_WAIT_B;
            ttb_pkg::B_WAIT_B: if (norm_rsp.done) state_next = ttb_pkg::B_OUT;
            ttb_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = (corner_reg == 2'd2) ? ttb_pkg::B_IDLE : ttb_pkg::B_DIFF;
                end
            end
            default: state_next = ttb_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(head.vertex_slot);
        pos_wdata = {head.pos_x, head.pos_y, head.pos_z};
        tex_wdata = {head.tex_u, head.tex_v};
        ram_raddr = AW'(idx_reg[0]);
        norm_req.start = 1'b0;
        norm_req.c0 = det_neg ? -t_reg[0] : t_reg[0];
        norm_req.c1 = det_neg ? -t_reg[1] : t_reg[1];
        norm_req.c2 = det_neg ? -t_reg[2] : t_reg[2];
        case (state_reg)
            ttb_pkg::B_IDLE:
            begin
                pop    = head_valid;
                ram_we = head_valid && (head.action == ttb_pkg::ACT_LOAD);
            end
            ttb_pkg::B_RD1: ram_raddr = AW'(idx_reg[1]);
            ttb_pkg::B_RD2: ram_raddr = AW'(idx_reg[2]);
            ttb_pkg::B_NORM_T: norm_req.start = 1'b1;
            ttb_pkg::B_NORM_B:
            begin
                norm_req.start = 1'b1;
                norm_req.c0 = det_neg ? -b_reg[0] : b_reg[0];
                norm_req.c1 = det_neg ? -b_reg[1] : b_reg[1];
                norm_req.c2 = det_neg ? -b_reg[2] : b_reg[2];
            end
            ttb_pkg::B_WAIT_B:
            begin
                norm_req.c0 = det_neg ? -b_reg[0] : b_reg[0];
                norm_req.c1 = det_neg ? -b_reg[1] : b_reg[1];
                norm_req.c2 = det_neg ? -b_reg[2] : b_reg[2];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ttb_pkg::B_OUT && out_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::B_IDLE:
            begin
                idx_reg[0] <= head.first_index;
                idx_reg[1] <= head.second_index;
                idx_reg[2] <= head.third_index;
                final_reg  <= head.final_triangle;
                corner_reg <= '0;
            end
            ttb_pkg::B_RD1: vtx_reg[0] <= rd_vtx;
            ttb_pkg::B_RD2: vtx_reg[1] <= rd_vtx;
            ttb_pkg::B_RD3: vtx_reg[2] <= rd_vtx;
            ttb_pkg::B_DIFF:
            begin
                e1_reg[0] <= DW'(vb.px) - DW'(va.px);
                e1_reg[1] <= DW'(vb.py) - DW'(va.py);
                e1_reg[2] <= DW'(vb.pz) - DW'(va.pz);
                e2_reg[0] <= DW'(vc.px) - DW'(va.px);
                e2_reg[1] <= DW'(vc.py) - DW'(va.py);
                e2_reg[2] <= DW'(vc.pz) - DW'(va.pz);
                d1u_reg   <= DW'(vb.tu) - DW'(va.tu);
                d1v_reg   <= DW'(vb.tv) - DW'(va.tv);
                d2u_reg   <= DW'(vc.tu) - DW'(va.tu);
                d2v_reg   <= DW'(vc.tv) - DW'(va.tv);
                step_reg  <= '0;
            end
            ttb_pkg::B_MUL:
            begin
                step_reg <= step_reg + 1'b1;
                if (!phase)
                begin
                    prod_reg <= mul_p;
                end
                else
                begin
                    case (term_sel)
                        3'd0:             det_reg <= term;
                        3'd1, 3'd2, 3'd3: t_reg[lane] <= term;
                        3'd4, 3'd5, 3'd6: b_reg[lane] <= term;
                        default:          det_reg <= term;
                    endcase
                end
            end
            ttb_pkg::B_WAIT_T:
            begin
                tcap_reg[0] <= norm_rsp.o0;
                tcap_reg[1] <= norm_rsp.o1;
                tcap_reg[2] <= norm_rsp.o2;
                zt_reg      <= norm_rsp.zero;
            end
            ttb_pkg::B_WAIT_B:
            begin
                bcap_reg[0] <= norm_rsp.o0;
                bcap_reg[1] <= norm_rsp.o1;
                bcap_reg[2] <= norm_rsp.o2;
                zb_reg      <= norm_rsp.zero;
            end
            ttb_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    slot_out_reg  <= idx_reg[corner_reg];
                    degen_out_reg <= degen_now;
                    last_out_reg  <= (corner_reg == 2'd2);
                    done_out_reg  <= (corner_reg == 2'd2) && final_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        tan_out_reg[i] <= degen_now ? '0 : tcap_reg[i];
                        bit_out_reg[i] <= degen_now ? '0 : bcap_reg[i];
                    end
                    corner_reg <= corner_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = ov_reg;
    assign target_slot  = slot_out_reg;
    assign tangent_x    = tan_out_reg[0];
    assign tangent_y    = tan_out_reg[1];
    assign tangent_z    = tan_out_reg[2];
    assign bitangent_x  = bit_out_reg[0];
    assign bitangent_y  = bit_out_reg[1];
    assign bitangent_z  = bit_out_reg[2];
    assign degenerate   = degen_out_reg;
    assign corner_last  = last_out_reg;
    assign mesh_done    = done_out_reg;

endmodule
`default_nettype wire

// ===== design/ttb_checker.sv =====
`default_nettype none
`include "triangle_tangent_bitangent_unit_defines.svh"
module ttb_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               result_valid,
    input wire logic                               result_stall,
    input wire logic [ttb_pkg::SLOT_W-1:0]         target_slot,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   tangent_x,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   tangent_y,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   tangent_z,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   bitangent_x,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   bitangent_y,
    input wire logic signed [ttb_pkg::OUT_W-1:0]   bitangent_z,
    input wire logic                               degenerate,
    input wire logic                               corner_last,
    input wire logic                               mesh_done
);

    // a stalled result beat stays put
    `TTB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(target_slot) && $stable(tangent_x) && $stable(bitangent_z))

    // end of mesh only on a triangle's third corner
    `TTB_ASSERT_SAME(a_done_on_last, result_valid && mesh_done, corner_last)

    // degenerate corners carry all-zero vectors
    `TTB_ASSERT_SAME(a_degen_zero, result_valid && degenerate, tangent_x == 0 && tangent_y == 0 && tangent_z == 0 && bitangent_x == 0 && bitangent_y == 0 && bitangent_z == 0)

    // tangent_x and bitangent_y never exceed one in Q1.14
    `TTB_ASSERT_SAME(a_unit_range, result_valid, tangent_x <= 16384 && tangent_x >= -16384 && bitangent_y <= 16384 && bitangent_y >= -16384)

endmodule

bind triangle_tangent_bitangent_unit ttb_checker u_ttb_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    // ------------------------------------------------------------------
    // Clock, reset, run limit
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 800;   // margin for one triangle to finish
    localparam int HOLD_CYCLES = 3000;   // long receiver hold-off, spans several triangles

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic                               item_valid = 1'b0;
    logic                               item_stall;
    logic                               action = ttb_pkg::ACT_LOAD;
    logic [ttb_pkg::SLOT_W-1:0]         vertex_slot = '0;
    logic signed [ttb_pkg::COORD_W-1:0] pos_x = '0;
    logic signed [ttb_pkg::COORD_W-1:0] pos_y = '0;
    logic signed [ttb_pkg::COORD_W-1:0] pos_z = '0;
    logic signed [ttb_pkg::COORD_W-1:0] tex_u = '0;
    logic signed [ttb_pkg::COORD_W-1:0] tex_v = '0;
    logic [ttb_pkg::SLOT_W-1:0]         first_index = '0;
    logic [ttb_pkg::SLOT_W-1:0]         second_index = '0;
    logic [ttb_pkg::SLOT_W-1:0]         third_index = '0;
    logic                               final_triangle = 1'b0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic [ttb_pkg::SLOT_W-1:0]         target_slot;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_x;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_y;
    logic signed [ttb_pkg::OUT_W-1:0]   tangent_z;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_x;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_y;
    logic signed [ttb_pkg::OUT_W-1:0]   bitangent_z;
    logic                               degenerate;
    logic                               corner_last;
    logic                               mesh_done;

    triangle_tangent_bitangent_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .vertex_slot    (vertex_slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .first_index    (first_index),
        .second_index   (second_index),
        .third_index    (third_index),
        .final_triangle (final_triangle),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .target_slot    (target_slot),
        .tangent_x      (tangent_x),
        .tangent_y      (tangent_y),
        .tangent_z      (tangent_z),
        .bitangent_x    (bitangent_x),
        .bitangent_y    (bitangent_y),
        .bitangent_z    (bitangent_z),
        .degenerate     (degenerate),
        .corner_last    (corner_last),
        .mesh_done      (mesh_done)
    );

    // ------------------------------------------------------------------
    // Shadow vertex store and expected corner queue
    // ------------------------------------------------------------------
    typedef struct {
        logic [ttb_pkg::SLOT_W-1:0] slot;
        logic [ttb_pkg::OUT_W-1:0]  tan_x, tan_y, tan_z;
        logic [ttb_pkg::OUT_W-1:0]  bit_x, bit_y, bit_z;
        logic                       degen;
        logic                       last;
        logic                       done;
    } corner_basis_t;

    longint        shadow_px [ttb_pkg::VERTEX_SLOTS];
    longint        shadow_py [ttb_pkg::VERTEX_SLOTS];
    longint        shadow_pz [ttb_pkg::VERTEX_SLOTS];
    longint        shadow_tu [ttb_pkg::VERTEX_SLOTS];
    longint        shadow_tv [ttb_pkg::VERTEX_SLOTS];
    int            loaded_slots[$];     // slots written since reset
    bit            slot_loaded [ttb_pkg::VERTEX_SLOTS];
    corner_basis_t pending_corners[$];

    int fail_count = 0;
    int loads_sent = 0;
    int triangles_sent = 0;
    int corners_seen = 0;
    int degenerate_seen = 0;
    int meshes_seen = 0;
    int stall_hits = 0;

    // ------------------------------------------------------------------
    // Predictor: integer square root, normalization, one corner
    // ------------------------------------------------------------------
    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale to Q1.14 unit length; returns 0 for an all-zero vector.
    function automatic bit to_unit_q14(input longint c0, c1, c2,
                                       output logic [ttb_pkg::OUT_W-1:0] o0, o1, o2);
        bit [63:0] m [3];
        bit        neg [3];
        bit [63:0] mx;
        bit [63:0] sumsq;
        bit [63:0] len;
        bit [63:0] q;
        longint    c [3];
        longint    r [3];
        c[0] = c0; c[1] = c1; c[2] = c2;
        mx = 0;
        for (int k = 0; k < 3; k++)
        begin
            neg[k] = c[k] < 0;
            m[k] = neg[k] ? -c[k] : c[k];
            if (m[k] > mx) mx = m[k];
        end
        o0 = '0; o1 = '0; o2 = '0;
        if (mx == 0) return 0;
        while (mx >= 64'd2147483648)
        begin
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
            mx = mx >> 1;
        end
        sumsq = 0;
        for (int k = 0; k < 3; k++) sumsq = sumsq + m[k] * m[k];
        len = int_sqrt(sumsq);
        for (int k = 0; k < 3; k++)
        begin
            q = (m[k] * ttb_pkg::UNIT_ONE + len / 2) / len;
            if (q > ttb_pkg::UNIT_ONE) q = ttb_pkg::UNIT_ONE;
            r[k] = neg[k] ? -longint'(q) : longint'(q);
        end
        o0 = r[0][ttb_pkg::OUT_W-1:0];
        o1 = r[1][ttb_pkg::OUT_W-1:0];
        o2 = r[2][ttb_pkg::OUT_W-1:0];
        return 1;
    endfunction

    // Corner a is the base, b and c the other two in cyclic order.
    function automatic corner_basis_t corner_basis(int a, int b, int c);
        corner_basis_t r;
        longint e1 [3];
        longint e2 [3];
        longint t [3];
        longint bt [3];
        longint d1u, d1v, d2u, d2v, det;
        bit     degen;
        e1[0] = shadow_px[b] - shadow_px[a];
        e1[1] = shadow_py[b] - shadow_py[a];
        e1[2] = shadow_pz[b] - shadow_pz[a];
        e2[0] = shadow_px[c] - shadow_px[a];
        e2[1] = shadow_py[c] - shadow_py[a];
        e2[2] = shadow_pz[c] - shadow_pz[a];
        d1u = shadow_tu[b] - shadow_tu[a];
        d1v = shadow_tv[b] - shadow_tv[a];
        d2u = shadow_tu[c] - shadow_tu[a];
        d2v = shadow_tv[c] - shadow_tv[a];
        det = d1u * d2v - d2u * d1v;
        for (int k = 0; k < 3; k++)
        begin
            t[k]  = d2v * e1[k] - d1v * e2[k];
            bt[k] = d1u * e2[k] - d2u * e1[k];
            if (det < 0)
            begin
                t[k]  = -t[k];
                bt[k] = -bt[k];
            end
        end
        degen = (det == 0);
        if (!degen && !to_unit_q14(t[0], t[1], t[2], r.tan_x, r.tan_y, r.tan_z))
            degen = 1;
        if (!degen && !to_unit_q14(bt[0], bt[1], bt[2], r.bit_x, r.bit_y, r.bit_z))
            degen = 1;
        if (degen)
        begin
            r.tan_x = '0; r.tan_y = '0; r.tan_z = '0;
            r.bit_x = '0; r.bit_y = '0; r.bit_z = '0;
        end
        r.slot  = a[ttb_pkg::SLOT_W-1:0];
        r.degen = degen;
        r.last  = 1'b0;
        r.done  = 1'b0;
        return r;
    endfunction

    // Update the shadow store or queue three corners for an accepted beat.
    task automatic predict_beat(ttb_pkg::item_t it);
        corner_basis_t r;
        int a, b, c;
        if (it.action == ttb_pkg::ACT_LOAD)
        begin
            a = it.vertex_slot;
            shadow_px[a] = it.pos_x;
            shadow_py[a] = it.pos_y;
            shadow_pz[a] = it.pos_z;
            shadow_tu[a] = it.tex_u;
            shadow_tv[a] = it.tex_v;
            if (!slot_loaded[a])
            begin
                slot_loaded[a] = 1;
                loaded_slots.push_back(a);
            end
            loads_sent++;
        end
        else
        begin
            a = it.first_index;
            b = it.second_index;
            c = it.third_index;
            pending_corners.push_back(corner_basis(a, b, c));
            pending_corners.push_back(corner_basis(b, c, a));
            r = corner_basis(c, a, b);
            r.last = 1'b1;
            r.done = it.final_triangle;
            pending_corners.push_back(r);
            triangles_sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one beat per call, bursts with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_beat(ttb_pkg::item_t it);
        action         <= it.action;
        vertex_slot    <= it.vertex_slot;
        pos_x          <= it.pos_x;
        pos_y          <= it.pos_y;
        pos_z          <= it.pos_z;
        tex_u          <= it.tex_u;
        tex_v          <= it.tex_v;
        first_index    <= it.first_index;
        second_index   <= it.second_index;
        third_index    <= it.third_index;
        final_triangle <= it.final_triangle;
        item_valid     <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!item_stall) break;
            stall_hits++;
        end
        predict_beat(it);
    endtask

    // Gap between bursts; stretches of back-to-back beats in between.
    task automatic pace(bit no_gaps);
        int gap;
        if (no_gaps) return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic ttb_pkg::item_t random_fields();
        ttb_pkg::item_t it;
        it.action         = $urandom_range(0, 1);
        it.vertex_slot    = $urandom;
        it.pos_x          = $urandom;
        it.pos_y          = $urandom;
        it.pos_z          = $urandom;
        it.tex_u          = $urandom;
        it.tex_v          = $urandom;
        it.first_index    = $urandom;
        it.second_index   = $urandom;
        it.third_index    = $urandom;
        it.final_triangle = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic ttb_pkg::item_t load_beat(int slot, int px, int py, int pz,
                                                 int tu, int tv);
        ttb_pkg::item_t it;
        it             = random_fields();   // triangle fields are don't-care
        it.action      = ttb_pkg::ACT_LOAD;
        it.vertex_slot = slot;
        it.pos_x       = px;
        it.pos_y       = py;
        it.pos_z       = pz;
        it.tex_u       = tu;
        it.tex_v       = tv;
        return it;
    endfunction

    function automatic ttb_pkg::item_t tri_beat(int a, int b, int c, bit last_tri);
        ttb_pkg::item_t it;
        it                = random_fields(); // load fields are don't-care
        it.action         = ttb_pkg::ACT_TRI;
        it.first_index    = a;
        it.second_index   = b;
        it.third_index    = c;
        it.final_triangle = last_tri;
        return it;
    endfunction

    function automatic int pick_loaded();
        return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    logic hold_token = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   stall_mode = 0;
    int   mode_left = 0;

    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(8, 200);
        end
        else
            mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= $urandom_range(0, 1);
                default: result_stall <= ($urandom_range(0, 7) != 0);
            endcase
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [ttb_pkg::OUT_W-1:0] exp_v,
                                        logic [ttb_pkg::OUT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d actual %0d", name,
                   $signed(exp_v), $signed(act_v));
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        corner_basis_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_corners.size() == 0)
            begin
                $error("unexpected result beat for slot %0d", target_slot);
                fail_count++;
            end
            else
            begin
                e = pending_corners.pop_front();
                check_field("target_slot", e.slot, target_slot);
                check_field("tangent_x", e.tan_x, tangent_x);
                check_field("tangent_y", e.tan_y, tangent_y);
                check_field("tangent_z", e.tan_z, tangent_z);
                check_field("bitangent_x", e.bit_x, bitangent_x);
                check_field("bitangent_y", e.bit_y, bitangent_y);
                check_field("bitangent_z", e.bit_z, bitangent_z);
                check_field("degenerate", e.degen, degenerate);
                check_field("corner_last", e.last, corner_last);
                check_field("mesh_done", e.done, mesh_done);
                corners_seen++;
                if (e.degen) degenerate_seen++;
                if (e.done) meshes_seen++;
            end
        end
    end

    // Run limit
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[triangle_tangent_bitangent_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme coordinates, slot 0 and 255, ignored triangle fields.
    task automatic test_extreme_loads();
        send_beat(load_beat(0, 0, 0, 0, 0, 0)); pace(0);
        send_beat(load_beat(1, 32767, 0, 0, 32767, 0)); pace(0);
        send_beat(load_beat(2, 0, -32768, 0, 0, -32768)); pace(0);
        send_beat(load_beat(255, -32768, 32767, -32768, -32768, 32767)); pace(0);
        send_beat(load_beat(254, 32767, 32767, 32767, 32767, 32767)); pace(0);
        // UVs on one line through slot 0: zero determinant
        send_beat(load_beat(3, 4096, -4096, 1234, 8192, 8192)); pace(0);
        send_beat(load_beat(4, -700, 300, 9000, 16384, 16384)); pace(0);
        // same position, distinct UVs: zero-length vectors
        send_beat(load_beat(5, 100, 100, 100, 0, 0)); pace(0);
        send_beat(load_beat(6, 100, 100, 100, 4096, 0)); pace(0);
        send_beat(load_beat(7, 100, 100, 100, 0, 4096)); pace(0);
    endtask

    // Regular, mirrored, degenerate and repeated-slot triangles, mesh end.
    task automatic test_special_triangles();
        send_beat(tri_beat(0, 1, 2, 0)); pace(0);
        send_beat(tri_beat(2, 1, 0, 0)); pace(0);      // reversed winding, positive determinant
        send_beat(tri_beat(255, 254, 1, 0)); pace(0);
        send_beat(tri_beat(0, 3, 4, 0)); pace(0);      // collinear UVs
        send_beat(tri_beat(5, 6, 7, 0)); pace(0);      // flat positions
        send_beat(tri_beat(1, 1, 2, 0)); pace(0);      // slot repeated
        send_beat(tri_beat(255, 255, 255, 0)); pace(0);
        send_beat(tri_beat(0, 1, 255, 1)); pace(0);    // final triangle
    endtask

    // Receiver holds off long enough for the queue to fill and the input to stall.
    task automatic test_output_hold();
        hold_token <= ~hold_token;
        for (int i = 0; i < 8; i++)
            send_beat(tri_beat(pick_loaded(), pick_loaded(), pick_loaded(),
                               $urandom_range(0, 1)));
        item_valid <= 1'b0;
    endtask

    // Mostly meshes: a few loads, then triangles over loaded slots; some noise.
    task automatic test_random_meshes(int beats);
        int sent;
        int n;
        sent = 0;
        while (sent < beats)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                send_beat(load_beat($urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
                pace(0);
                sent++;
            end
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(tri_beat(pick_loaded(), pick_loaded(), pick_loaded(),
                                       $urandom_range(0, 1)));
                else
                    send_beat(tri_beat(pick_loaded(), pick_loaded(), pick_loaded(),
                                       (i == n - 1) && ($urandom_range(0, 2) == 0)));
                pace(0);
                sent++;
            end
        end
        item_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_loads();
        test_special_triangles();
        test_output_hold();
        test_random_meshes(350);

        // drain, then a margin of one triangle's latency for stray beats
        while (pending_corners.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_corners.size() != 0)
        begin
            $error("%0d expected corners never arrived", pending_corners.size());
            fail_count++;
        end

        $display("Covered %0d loads and %0d triangles, %0d corners checked",
                 loads_sent, triangles_sent, corners_seen);
        $display("(%0d degenerate, %0d mesh ends, %0d input stall cycles)",
                 degenerate_seen, meshes_seen, stall_hits);
        if (fail_count == 0)
            $display("[triangle_tangent_bitangent_unit] OK");
        else
            $display("[triangle_tangent_bitangent_unit] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
